### src/vmos_pkg.sv
// Package: constants, codes and controller/datapath types of the operand stack unit.
`default_nettype none
package vmos_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int TYPE_BITS   = 4;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  localparam int FUNC_W   = 4;
  localparam int VALUE_W  = 32;
  localparam int VTYPE_W  = 4;
  localparam int STATUS_W = 3;

  typedef logic [TYPE_BITS-1:0] vtype_t;

  localparam vtype_t I32_TAG = vtype_t'(2);

  typedef struct packed {
    vtype_t             vtype;
    logic [VALUE_W-1:0] value;
  } entry_t;

  typedef enum logic [FUNC_W-1:0] {
    FN_HALT       = 4'd0,
    FN_PUSH       = 4'd1,
    FN_PUSH_ADDR  = 4'd2,
    FN_PUSH_TYPED = 4'd3,
    FN_POP        = 4'd4,
    FN_DUP        = 4'd5,
    FN_SWAP       = 4'd6,
    FN_ROT        = 4'd7
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 3'd0,
    ST_OVER   = 3'd1,
    ST_UNDER  = 3'd2,
    ST_BAD    = 3'd3,
    ST_HALTED = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_CAP0,
    S_CAP1,
    S_CAP2,
    S_WR_DUP,
    S_WR_A,
    S_WR_B,
    S_WR_C,
    S_RESP
  } state_t;

  typedef enum logic [1:0] {
    RD_TOP,
    RD_SEC,
    RD_THIRD
  } rd_sel_t;

  typedef enum logic [2:0] {
    WR_PUSH_INT,
    WR_PUSH_TYPED,
    WR_DUP,
    WR_TOP_T1,
    WR_TOP_T2,
    WR_SEC,
    WR_THIRD
  } wr_sel_t;

  typedef struct packed {
    logic    latch_in;
    rd_sel_t rd_sel;
    logic    cap0;
    logic    cap1;
    logic    cap2;
    logic    wr_en;
    wr_sel_t wr_sel;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    st_load;
    status_t st_code;
    logic    clr_active;
    logic    pop_set;
    logic    load_out;
  } cmd_t;

  typedef struct packed {
    logic  in_valid;
    func_t func;
    logic  active;
    logic  empty;
    logic  lt2;
    logic  lt3;
    logic  full;
    logic  out_free;
  } sts_t;

endpackage
`default_nettype wire

### src/vmos_in_if.sv
// Interface: input channel carrying one stack operation per transfer.
`default_nettype none
interface vmos_in_if;
  logic                         valid;
  logic                         ready;
  logic [vmos_pkg::FUNC_W-1:0]  func;
  logic [vmos_pkg::VALUE_W-1:0] value;
  logic [vmos_pkg::VTYPE_W-1:0] value_type;

  modport source (output valid, output func, output value, output value_type, input ready);
  modport sink   (input valid, input func, input value, input value_type, output ready);
endinterface
`default_nettype wire

### src/vmos_out_if.sv
// Interface: result channel carrying one result per transfer.
`default_nettype none
interface vmos_out_if;
  logic                          valid;
  logic                          ready;
  logic [vmos_pkg::VALUE_W-1:0]  pop_value;
  logic [vmos_pkg::VTYPE_W-1:0]  pop_type;
  logic [vmos_pkg::STATUS_W-1:0] status;
  logic                          running;

  modport source (output valid, output pop_value, output pop_type, output status,
                  output running, input ready);
  modport sink   (input valid, input pop_value, input pop_type, input status,
                  input running, output ready);
endinterface
`default_nettype wire

### src/vmos_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module vmos_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### src/vmos_ctrl.sv
// Controller: sequences accept, decode, stack reads, write-back and result load.
`default_nettype none
module vmos_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire vmos_pkg::sts_t   sts,
  output vmos_pkg::cmd_t        cmd,
  output logic                  in_ready
);

  vmos_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vmos_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      vmos_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (sts.in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = vmos_pkg::S_EXEC;
        end
      end
      vmos_pkg::S_EXEC: begin
        cmd.st_load = 1'b1;
        cmd.rd_sel  = vmos_pkg::RD_TOP;
        state_nxt   = vmos_pkg::S_RESP;
        if (!sts.active) begin
          cmd.st_code = vmos_pkg::ST_HALTED;
        end else begin
          unique case (sts.func)
            vmos_pkg::FN_HALT: begin
              cmd.st_code    = vmos_pkg::ST_OK;
              cmd.clr_active = 1'b1;
            end
            vmos_pkg::FN_PUSH, vmos_pkg::FN_PUSH_TYPED: begin
              if (sts.full) begin
                cmd.st_code    = vmos_pkg::ST_OVER;
                cmd.clr_active = 1'b1;
              end else begin
                cmd.st_code = vmos_pkg::ST_OK;
                cmd.wr_en   = 1'b1;
                cmd.wr_sel  = (sts.func == vmos_pkg::FN_PUSH) ? vmos_pkg::WR_PUSH_INT
                                                              : vmos_pkg::WR_PUSH_TYPED;
                cmd.cnt_inc = 1'b1;
              end
            end
            vmos_pkg::FN_POP: begin
              if (sts.empty) begin
                cmd.st_code    = vmos_pkg::ST_UNDER;
                cmd.clr_active = 1'b1;
              end else begin
                cmd.st_code = vmos_pkg::ST_OK;
                state_nxt   = vmos_pkg::S_CAP0;
              end
            end
            vmos_pkg::FN_DUP: begin
              if (sts.empty) begin
                cmd.st_code    = vmos_pkg::ST_UNDER;
                cmd.clr_active = 1'b1;
              end else if (sts.full) begin
                cmd.st_code    = vmos_pkg::ST_OVER;
                cmd.clr_active = 1'b1;
              end else begin
                cmd.st_code = vmos_pkg::ST_OK;
                state_nxt   = vmos_pkg::S_CAP0;
              end
            end
            vmos_pkg::FN_SWAP: begin
              if (sts.lt2) begin
                cmd.st_code    = vmos_pkg::ST_UNDER;
                cmd.clr_active = 1'b1;
              end else begin
                cmd.st_code = vmos_pkg::ST_OK;
                state_nxt   = vmos_pkg::S_CAP0;
              end
            end
            vmos_pkg::FN_ROT: begin
              if (sts.lt3) begin
                cmd.st_code    = vmos_pkg::ST_UNDER;
                cmd.clr_active = 1'b1;
              end else begin
                cmd.st_code = vmos_pkg::ST_OK;
                state_nxt   = vmos_pkg::S_CAP0;
              end
            end
            default: begin
              cmd.st_code    = vmos_pkg::ST_BAD;
              cmd.clr_active = 1'b1;
            end
          endcase
        end
      end
      vmos_pkg::S_CAP0: begin
        cmd.cap0   = 1'b1;
        cmd.rd_sel = vmos_pkg::RD_SEC;
        unique case (sts.func)
          vmos_pkg::FN_POP: begin
            cmd.pop_set = 1'b1;
            cmd.cnt_dec = 1'b1;
            state_nxt   = vmos_pkg::S_RESP;
          end
          vmos_pkg::FN_DUP:                  state_nxt = vmos_pkg::S_WR_DUP;
          vmos_pkg::FN_SWAP, vmos_pkg::FN_ROT: state_nxt = vmos_pkg::S_CAP1;
          default:                           state_nxt = vmos_pkg::S_RESP;
        endcase
      end
      vmos_pkg::S_CAP1: begin
        cmd.cap1   = 1'b1;
        cmd.rd_sel = vmos_pkg::RD_THIRD;
        state_nxt  = (sts.func == vmos_pkg::FN_ROT) ? vmos_pkg::S_CAP2 : vmos_pkg::S_WR_A;
      end
      vmos_pkg::S_CAP2: begin
        cmd.cap2  = 1'b1;
        state_nxt = vmos_pkg::S_WR_A;
      end
      vmos_pkg::S_WR_DUP: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = vmos_pkg::WR_DUP;
        cmd.cnt_inc = 1'b1;
        state_nxt   = vmos_pkg::S_RESP;
      end
      vmos_pkg::S_WR_A: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = (sts.func == vmos_pkg::FN_ROT) ? vmos_pkg::WR_TOP_T2 : vmos_pkg::WR_TOP_T1;
        state_nxt  = vmos_pkg::S_WR_B;
      end
      vmos_pkg::S_WR_B: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = vmos_pkg::WR_SEC;
        state_nxt  = (sts.func == vmos_pkg::FN_ROT) ? vmos_pkg::S_WR_C : vmos_pkg::S_RESP;
      end
      vmos_pkg::S_WR_C: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = vmos_pkg::WR_THIRD;
        state_nxt  = vmos_pkg::S_RESP;
      end
      vmos_pkg::S_RESP: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = vmos_pkg::S_IDLE;
        end
      end
      default: state_nxt = vmos_pkg::S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

### src/vmos_dp.sv
// Datapath: operand latch, stack RAM, pointer, top-entry holding registers and result register.
`default_nettype none
module vmos_dp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire vmos_pkg::cmd_t                cmd,
  output vmos_pkg::sts_t                     sts,
  input  wire logic                          in_valid,
  input  wire logic [vmos_pkg::FUNC_W-1:0]   in_func,
  input  wire logic [vmos_pkg::VALUE_W-1:0]  in_value,
  input  wire logic [vmos_pkg::VTYPE_W-1:0]  in_vtype,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [vmos_pkg::VALUE_W-1:0]  out_pop_value,
  output logic      [vmos_pkg::VTYPE_W-1:0]  out_pop_type,
  output logic      [vmos_pkg::STATUS_W-1:0] out_status,
  output logic                               out_running
);

  localparam int CNT_W  = vmos_pkg::CNT_W;
  localparam int ADDR_W = vmos_pkg::ADDR_W;

  logic [vmos_pkg::FUNC_W-1:0]  func_r;
  logic [vmos_pkg::VALUE_W-1:0] value_r;
  logic [vmos_pkg::VTYPE_W-1:0] vtype_r;

  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              active_r;
  vmos_pkg::status_t status_r;
  logic              pop_r;
  vmos_pkg::entry_t  t0_r, t1_r, t2_r;

  logic              out_valid_r;
  logic [vmos_pkg::VALUE_W-1:0]  pop_value_r;
  logic [vmos_pkg::VTYPE_W-1:0]  pop_type_r;
  logic [vmos_pkg::STATUS_W-1:0] status_out_r;
  logic              running_r;

  logic [CNT_W-1:0]  cnt_m1, cnt_m2, cnt_m3;
  logic [ADDR_W-1:0] raddr, waddr;
  vmos_pkg::entry_t  wdata, rdata;

  assign cnt_m1 = count_r - CNT_W'(1);
  assign cnt_m2 = count_r - CNT_W'(2);
  assign cnt_m3 = count_r - CNT_W'(3);

  always_comb begin
    unique case (cmd.rd_sel)
      vmos_pkg::RD_TOP:   raddr = cnt_m1[ADDR_W-1:0];
      vmos_pkg::RD_SEC:   raddr = cnt_m2[ADDR_W-1:0];
      vmos_pkg::RD_THIRD: raddr = cnt_m3[ADDR_W-1:0];
      default:            raddr = cnt_m1[ADDR_W-1:0];
    endcase
  end

  always_comb begin
    unique case (cmd.wr_sel)
      vmos_pkg::WR_PUSH_INT: begin
        waddr = count_r[ADDR_W-1:0];
        wdata = '{vtype: vmos_pkg::I32_TAG, value: value_r};
      end
      vmos_pkg::WR_PUSH_TYPED: begin
        waddr = count_r[ADDR_W-1:0];
        wdata = '{vtype: vmos_pkg::vtype_t'(vtype_r), value: value_r};
      end
      vmos_pkg::WR_DUP: begin
        waddr = count_r[ADDR_W-1:0];
        wdata = t0_r;
      end
      vmos_pkg::WR_TOP_T1: begin
        waddr = cnt_m1[ADDR_W-1:0];
        wdata = t1_r;
      end
      vmos_pkg::WR_TOP_T2: begin
        waddr = cnt_m1[ADDR_W-1:0];
        wdata = t2_r;
      end
      vmos_pkg::WR_SEC: begin
        waddr = cnt_m2[ADDR_W-1:0];
        wdata = t0_r;
      end
      vmos_pkg::WR_THIRD: begin
        waddr = cnt_m3[ADDR_W-1:0];
        wdata = t1_r;
      end
      default: begin
        waddr = count_r[ADDR_W-1:0];
        wdata = t0_r;
      end
    endcase
  end

  vmos_ram #(
    .WIDTH ($bits(vmos_pkg::entry_t)),
    .DEPTH (vmos_pkg::STACK_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    count_nxt = count_r;
    if (cmd.cnt_inc) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.cnt_dec) begin
      count_nxt = cnt_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      active_r    <= 1'b1;
      pop_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (cmd.clr_active) begin
        active_r <= 1'b0;
      end
      if (cmd.latch_in) begin
        pop_r <= 1'b0;
      end else if (cmd.pop_set) begin
        pop_r <= 1'b1;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      func_r  <= in_func;
      value_r <= in_value;
      vtype_r <= in_vtype;
    end
    if (cmd.st_load) begin
      status_r <= cmd.st_code;
    end
    if (cmd.cap0) begin
      t0_r <= rdata;
    end
    if (cmd.cap1) begin
      t1_r <= rdata;
    end
    if (cmd.cap2) begin
      t2_r <= rdata;
    end
    if (cmd.load_out) begin
      pop_value_r  <= pop_r ? t0_r.value : '0;
      pop_type_r   <= pop_r ? 4'(t0_r.vtype) : '0;
      status_out_r <= status_r;
      running_r    <= active_r;
    end
  end

  assign sts.in_valid = in_valid;
  assign sts.func     = vmos_pkg::func_t'(func_r);
  assign sts.active   = active_r;
  assign sts.empty    = (count_r == '0);
  assign sts.lt2      = (count_r < CNT_W'(2));
  assign sts.lt3      = (count_r < CNT_W'(3));
  assign sts.full     = (count_r == CNT_W'(vmos_pkg::STACK_DEPTH));
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid     = out_valid_r;
  assign out_pop_value = pop_value_r;
  assign out_pop_type  = pop_type_r;
  assign out_status    = status_out_r;
  assign out_running   = running_r;

endmodule
`default_nettype wire

### src/vm_operand_stack_unit_top.sv
// Top level of the operand stack unit: controller, datapath and channel wiring.
//
//   channel  role    payload                               transfer when
//   in_if    sink    func, value, value_type               in_if.valid & in_if.ready
//   out_if   source  pop_value, pop_type, status, running  out_if.valid & out_if.ready
//
// One item at a time; all stack traffic goes through one RAM write and one
// registered read port, so dup, swap and rot read and write their entries in
// turn, and each result is held in the result register until out_if.ready.
// A new item is taken while the previous result still waits in the output register.
// Reset (rst_n low, synchronous) empties the stack and starts the machine running;
// stack RAM contents are not cleared and need no clearing pass.
`default_nettype none
module vm_operand_stack_unit_top (
  input wire logic clk,
  input wire logic rst_n,
  vmos_in_if.sink    in_if,
  vmos_out_if.source out_if
);

  vmos_pkg::cmd_t cmd;
  vmos_pkg::sts_t sts;

  vmos_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .sts      (sts),
    .cmd      (cmd),
    .in_ready (in_if.ready)
  );

  vmos_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_valid      (in_if.valid),
    .in_func       (in_if.func),
    .in_value      (in_if.value),
    .in_vtype      (in_if.value_type),
    .out_valid     (out_if.valid),
    .out_ready     (out_if.ready),
    .out_pop_value (out_if.pop_value),
    .out_pop_type  (out_if.pop_type),
    .out_status    (out_if.status),
    .out_running   (out_if.running)
  );

endmodule
`default_nettype wire

### verif/tb.sv
// Testbench for the operand stack unit: shadow-stack prediction, random handshakes, result check.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import vmos_pkg::*;

  localparam int LONG_HOLD    = 200;
  localparam int PHASE_ITEMS  = 500;
  localparam int TABLE_ROWS   = 23;
  localparam int SETTLE       = 20;
  localparam int NUM_FUNCS    = 2 ** FUNC_W;
  localparam int PRINT_LIMIT  = 40;

  typedef struct packed {
    logic [VALUE_W-1:0] pop_value;
    logic [VTYPE_W-1:0] pop_type;
    status_t            status;
    logic               running;
  } result_t;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [VALUE_W-1:0] value;
    logic [VTYPE_W-1:0] vtype;
    logic               typed;
    result_t            want;
  } stim_row_t;

  localparam result_t NO_CHECK = '0;
  localparam result_t RES_OK   = {32'h0, 4'h0, ST_OK, 1'b1};

  // typed rows: opening pushes and pops of extremes, and a rot on distinct entries
  stim_row_t dir_table [TABLE_ROWS] = '{
    {FN_PUSH,       32'h0000_0000, 4'h0, 1'b1, RES_OK},
    {FN_PUSH,       32'hFFFF_FFFF, 4'hF, 1'b1, RES_OK},
    {FN_PUSH_TYPED, 32'h8000_0001, 4'h0, 1'b1, RES_OK},
    {FN_PUSH_TYPED, 32'h7FFF_FFFE, 4'hF, 1'b1, RES_OK},
    {FN_POP,        32'h0,         4'h0, 1'b1, {32'h7FFF_FFFE, 4'hF, ST_OK, 1'b1}},
    {FN_POP,        32'h0,         4'h0, 1'b1, {32'h8000_0001, 4'h0, ST_OK, 1'b1}},
    {FN_POP,        32'h0,         4'h0, 1'b1, {32'hFFFF_FFFF, I32_TAG, ST_OK, 1'b1}},
    {FN_POP,        32'h0,         4'h0, 1'b1, {32'h0000_0000, I32_TAG, ST_OK, 1'b1}},
    {FN_PUSH_TYPED, 32'hA5A5_A5A5, 4'h5, 1'b0, NO_CHECK},
    {FN_DUP,        32'h0,         4'h0, 1'b0, NO_CHECK},
    {FN_PUSH,       32'h1234_5678, 4'hA, 1'b0, NO_CHECK},
    {FN_SWAP,       32'h0,         4'h0, 1'b0, NO_CHECK},
    {FN_ROT,        32'h0,         4'h0, 1'b0, NO_CHECK},
    {FN_POP,        32'h0,         4'h0, 1'b0, NO_CHECK},
    {FN_POP,        32'h0,         4'h0, 1'b0, NO_CHECK},
    {FN_POP,        32'h0,         4'h0, 1'b0, NO_CHECK},
    {FN_PUSH_TYPED, 32'h1111_1111, 4'h1, 1'b1, RES_OK},
    {FN_PUSH_TYPED, 32'h2222_2222, 4'h3, 1'b1, RES_OK},
    {FN_PUSH_TYPED, 32'h3333_3333, 4'h7, 1'b1, RES_OK},
    {FN_ROT,        32'h0,         4'h0, 1'b1, RES_OK},
    {FN_POP,        32'h0,         4'h0, 1'b1, {32'h1111_1111, 4'h1, ST_OK, 1'b1}},
    {FN_POP,        32'h0,         4'h0, 1'b1, {32'h3333_3333, 4'h7, ST_OK, 1'b1}},
    {FN_POP,        32'h0,         4'h0, 1'b1, {32'h2222_2222, 4'h3, ST_OK, 1'b1}}
  };

  logic clk;
  logic rst_n;

  vmos_in_if  in_ch ();
  vmos_out_if out_ch ();

  vm_operand_stack_unit_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  entry_t  shadow_stack [STACK_DEPTH];
  int      shadow_depth   = 0;
  bit      shadow_running = 1'b1;
  bit      climbing       = 1'b1;
  result_t pending_results [$];

  int    sender_idle_pct   = 0;
  int    receiver_idle_pct = 0;
  bit    long_hold_req     = 1'b0;
  int    mismatches        = 0;
  int    results_checked   = 0;
  int    ops_run [NUM_FUNCS];
  int    halted_items      = 0;
  int    peak_depth        = 0;
  int    full_hits         = 0;
  string stop_cause        = "nothing";

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("Timeout with %0d results outstanding", pending_results.size());
    $display("*** FAILED ***");
    $finish;
  end

  function automatic status_t push_shadow(input logic [VALUE_W-1:0] v, input vtype_t t);
    if (shadow_depth >= STACK_DEPTH) return ST_OVER;
    shadow_stack[shadow_depth].value = v;
    shadow_stack[shadow_depth].vtype = t;
    shadow_depth++;
    return ST_OK;
  endfunction

  function automatic result_t apply_stack_op(input logic [FUNC_W-1:0] f,
                                             input logic [VALUE_W-1:0] v,
                                             input logic [VTYPE_W-1:0] t);
    result_t r;
    entry_t  e;
    r = '0;
    if (!shadow_running) begin
      r.status = ST_HALTED;
    end else begin
      case (f)
        FN_HALT:       shadow_running = 1'b0;
        FN_PUSH:       r.status = push_shadow(v, I32_TAG);
        FN_PUSH_TYPED: r.status = push_shadow(v, vtype_t'(t));
        FN_POP: begin
          if (shadow_depth == 0) begin
            r.status = ST_UNDER;
          end else begin
            shadow_depth--;
            r.pop_value = shadow_stack[shadow_depth].value;
            r.pop_type  = shadow_stack[shadow_depth].vtype;
          end
        end
        FN_DUP: begin
          if (shadow_depth == 0) begin
            r.status = ST_UNDER;
          end else begin
            e = shadow_stack[shadow_depth-1];
            r.status = push_shadow(e.value, e.vtype);
          end
        end
        FN_SWAP: begin
          if (shadow_depth < 2) begin
            r.status = ST_UNDER;
          end else begin
            e = shadow_stack[shadow_depth-1];
            shadow_stack[shadow_depth-1] = shadow_stack[shadow_depth-2];
            shadow_stack[shadow_depth-2] = e;
          end
        end
        FN_ROT: begin
          if (shadow_depth < 3) begin
            r.status = ST_UNDER;
          end else begin
            e = shadow_stack[shadow_depth-3];
            shadow_stack[shadow_depth-3] = shadow_stack[shadow_depth-2];
            shadow_stack[shadow_depth-2] = shadow_stack[shadow_depth-1];
            shadow_stack[shadow_depth-1] = e;
          end
        end
        default: r.status = ST_BAD;
      endcase
      if (r.status != ST_OK) shadow_running = 1'b0;
    end
    r.running = shadow_running;
    return r;
  endfunction

  function automatic bit op_is_safe(input logic [FUNC_W-1:0] f);
    case (f)
      FN_PUSH, FN_PUSH_TYPED: return shadow_depth < STACK_DEPTH;
      FN_POP:                 return shadow_depth >= 1;
      FN_DUP:                 return shadow_depth >= 1 && shadow_depth < STACK_DEPTH;
      FN_SWAP:                return shadow_depth >= 2;
      FN_ROT:                 return shadow_depth >= 3;
      default:                return 1'b0;
    endcase
  endfunction

  // walks the stack up to full and back down to empty, never stopping the machine
  function automatic logic [FUNC_W-1:0] pick_legal_op();
    int unsigned r;
    logic [FUNC_W-1:0] f;
    r = $urandom_range(99);
    if (shadow_depth == STACK_DEPTH) climbing = 1'b0;
    else if (shadow_depth == 0) climbing = 1'b1;
    else if ($urandom_range(99) < 3) climbing = !climbing;
    if (climbing) begin
      if (r < 30) f = FN_PUSH;
      else if (r < 55) f = FN_PUSH_TYPED;
      else if (r < 70) f = FN_DUP;
      else if (r < 80) f = FN_SWAP;
      else if (r < 90) f = FN_ROT;
      else f = FN_POP;
    end else begin
      if (r < 55) f = FN_POP;
      else if (r < 70) f = FN_SWAP;
      else if (r < 85) f = FN_ROT;
      else if (r < 90) f = FN_PUSH;
      else if (r < 95) f = FN_PUSH_TYPED;
      else f = FN_DUP;
    end
    if (!op_is_safe(f)) f = (shadow_depth < STACK_DEPTH) ? FN_PUSH : FN_POP;
    return f;
  endfunction

  function automatic logic [VALUE_W-1:0] rand_word();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [VTYPE_W-1:0] rand_tag();
    return VTYPE_W'($urandom_range(15));
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < PRINT_LIMIT)
      $display("Mismatch on %s at result %0d: got 0x%0h, expected 0x%0h",
               what, results_checked, got, want);
    mismatches++;
  endtask

  task automatic offer(input logic [FUNC_W-1:0] f, input logic [VALUE_W-1:0] v,
                       input logic [VTYPE_W-1:0] t, input bit typed, input result_t want);
    result_t predicted;
    int      depth_was;
    if ($urandom_range(99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    in_ch.valid      <= 1'b1;
    in_ch.func       <= f;
    in_ch.value      <= v;
    in_ch.value_type <= t;
    do @(posedge clk); while (!in_ch.ready);
    if (shadow_running) ops_run[f]++;
    else halted_items++;
    depth_was = shadow_depth;
    predicted = apply_stack_op(f, v, t);
    pending_results.push_back(typed ? want : predicted);
    if (shadow_depth > peak_depth) peak_depth = shadow_depth;
    if (shadow_depth == STACK_DEPTH && depth_was < STACK_DEPTH) full_hits++;
  endtask

  task automatic run_random(input int n);
    for (int i = 0; i < n; i++)
      offer(pick_legal_op(), rand_word(), rand_tag(), 1'b0, NO_CHECK);
  endtask

  // one run, one reset: the machine can only be stopped once, by a cause picked here
  task automatic stop_machine();
    logic [FUNC_W-1:0] trigger;
    status_t           code;
    int                need;
    int                target;
    code = ST_OK;
    need = 1;
    case ($urandom_range(4))
      0: begin
        stop_cause = "halt";
        trigger = FN_HALT;
      end
      1: begin
        stop_cause = "overflow";
        code = ST_OVER;
        while (shadow_depth < STACK_DEPTH)
          offer(FN_PUSH_TYPED, rand_word(), rand_tag(), 1'b0, NO_CHECK);
        case ($urandom_range(2))
          0:       trigger = FN_PUSH;
          1:       trigger = FN_PUSH_TYPED;
          default: trigger = FN_DUP;
        endcase
      end
      2: begin
        stop_cause = "underflow";
        code = ST_UNDER;
        case ($urandom_range(3))
          0:       trigger = FN_POP;
          1:       trigger = FN_DUP;
          2: begin
            trigger = FN_SWAP;
            need = 2;
          end
          default: begin
            trigger = FN_ROT;
            need = 3;
          end
        endcase
        target = $urandom_range(need - 1);
        while (shadow_depth > target)
          offer(FN_POP, rand_word(), rand_tag(), 1'b0, NO_CHECK);
        while (shadow_depth < target)
          offer(FN_PUSH, rand_word(), rand_tag(), 1'b0, NO_CHECK);
      end
      3: begin
        stop_cause = "address push";
        code = ST_BAD;
        trigger = FN_PUSH_ADDR;
      end
      default: begin
        stop_cause = "unknown operation";
        code = ST_BAD;
        trigger = FUNC_W'($urandom_range(NUM_FUNCS - 1, FN_ROT + 1));
      end
    endcase
    offer(trigger, rand_word(), rand_tag(), 1'b1, {32'h0, 4'h0, code, 1'b0});
  endtask

  // receiver: random back-pressure, plus one long hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      out_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected transfer", out_ch.pop_value, '0);
      end else begin
        want = pending_results.pop_front();
        if (out_ch.pop_value !== want.pop_value)
          report_mismatch("pop_value", out_ch.pop_value, want.pop_value);
        if (out_ch.pop_type !== want.pop_type)
          report_mismatch("pop_type", 32'(out_ch.pop_type), 32'(want.pop_type));
        if (out_ch.status !== want.status)
          report_mismatch("status", 32'(out_ch.status), 32'(want.status));
        if (out_ch.running !== want.running)
          report_mismatch("running", 32'(out_ch.running), 32'(want.running));
      end
      results_checked++;
    end
  end

  initial begin
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.func       <= '0;
    in_ch.value      <= '0;
    in_ch.value_type <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    sender_idle_pct   = 8;
    receiver_idle_pct = 66;
    foreach (dir_table[i])
      offer(dir_table[i].func, dir_table[i].value, dir_table[i].vtype,
            dir_table[i].typed, dir_table[i].want);
    run_random(PHASE_ITEMS);

    sender_idle_pct   = 66;
    receiver_idle_pct = 8;
    run_random(PHASE_ITEMS);

    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    long_hold_req     = 1'b1;
    run_random(PHASE_ITEMS);

    stop_machine();
    for (int f = 0; f < NUM_FUNCS; f++)
      offer(FUNC_W'(f), rand_word(), rand_tag(), 1'b1, {32'h0, 4'h0, ST_HALTED, 1'b0});
    in_ch.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("%0d results checked: %0d push, %0d typed push, %0d pop, %0d dup, %0d swap, %0d rot",
             results_checked, ops_run[FN_PUSH], ops_run[FN_PUSH_TYPED], ops_run[FN_POP],
             ops_run[FN_DUP], ops_run[FN_SWAP], ops_run[FN_ROT]);
    $display("Deepest stack %0d, full %0d times; stopped by %s, then %0d items refused",
             peak_depth, full_hits, stop_cause, halted_items);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
